>>> sv/spse_pkg.sv
package spse_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned ID_W   = 6;
  localparam int unsigned SIZE_W = 16;
  localparam int unsigned LOC_W  = 22;
  localparam int unsigned CNT_W  = 7;

  typedef struct packed {
    logic [ID_W-1:0]   x_order_entry;
    logic [ID_W-1:0]   y_order_entry;
    logic [SIZE_W-1:0] module_width;
    logic [SIZE_W-1:0] module_height;
    logic              last_item;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]  module_index;
    logic [LOC_W-1:0] x_position;
    logic [LOC_W-1:0] y_position;
    logic [LOC_W-1:0] x_slack;
    logic [LOC_W-1:0] y_slack;
    logic [LOC_W-1:0] layout_width;
    logic [LOC_W-1:0] layout_height;
    logic             last_result;
  } out_item_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

endpackage

>>> sv/spse_alu.sv
module spse_alu (
  input  spse_pkg::alu_op_e              op_i,
  input  logic [spse_pkg::LOC_W-1:0]     a_i,
  input  logic [spse_pkg::LOC_W-1:0]     b_i,
  output logic [spse_pkg::LOC_W-1:0]     res_o,
  output logic                           gt_o
);

  always_comb begin
    case (op_i)
      spse_pkg::ALU_ADD: res_o = a_i + b_i;
      spse_pkg::ALU_SUB: res_o = a_i - b_i;
      default:           res_o = a_i;
    endcase
  end

  assign gt_o = a_i > b_i;

endmodule

>>> sv/sequence_pair_slack_evaluator_unit.sv
// Sequence-pair slack evaluator. Positions of the X and Y orders are loaded one
// transaction per cycle together with the size of the module of that index; the
// transaction marked last starts evaluation and the input stalls until the last
// result has been handed to the output register. Evaluation runs four weighted-LCS
// passes through one shared add/subtract/compare unit and registered-read block
// memories: each pass first builds the match table, then per position reads the
// order and the match, writes its location and compares running-length entries
// (at least one, at most n-p), then fetches the total. Emitting steps through the
// states S_O0 to S_O8 per module and waits in S_O8 while the output is stalled. The
// module size inputs are masked to SIZE_BITS bits.
module sequence_pair_slack_evaluator_unit #(
  parameter int unsigned MAX_MODULES = 64,
  parameter int unsigned SIZE_BITS   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  spse_pkg::in_item_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output spse_pkg::out_item_t   out_data_o
);

  localparam int unsigned IW = spse_pkg::ID_W;
  localparam int unsigned LW = spse_pkg::LOC_W;
  localparam int unsigned SW = spse_pkg::SIZE_W;
  localparam int unsigned CW = spse_pkg::CNT_W;
  localparam logic [SW-1:0] SizeMask =
    (SIZE_BITS >= SW) ? {SW{1'b1}} : SW'((32'd1 << SIZE_BITS) - 32'd1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_MODULES);

  localparam logic [4:0] S_LOAD = 5'd0;
  localparam logic [4:0] S_INIT = 5'd1;
  localparam logic [4:0] S_BRD  = 5'd2;
  localparam logic [4:0] S_BWR  = 5'd3;
  localparam logic [4:0] S_XRD  = 5'd4;
  localparam logic [4:0] S_MRD  = 5'd5;
  localparam logic [4:0] S_PSEL = 5'd6;
  localparam logic [4:0] S_LRD  = 5'd7;
  localparam logic [4:0] S_LWR  = 5'd8;
  localparam logic [4:0] S_URD  = 5'd9;
  localparam logic [4:0] S_UCMP = 5'd10;
  localparam logic [4:0] S_ERD  = 5'd11;
  localparam logic [4:0] S_EWR  = 5'd12;
  localparam logic [4:0] S_O0   = 5'd13;
  localparam logic [4:0] S_O1   = 5'd14;
  localparam logic [4:0] S_O2   = 5'd15;
  localparam logic [4:0] S_O3   = 5'd16;
  localparam logic [4:0] S_O4   = 5'd17;
  localparam logic [4:0] S_O5   = 5'd18;
  localparam logic [4:0] S_O6   = 5'd19;
  localparam logic [4:0] S_O7   = 5'd20;
  localparam logic [4:0] S_O8   = 5'd21;

  localparam int unsigned DEPTH_BITS = spse_pkg::DEPTH;

  logic [4:0]    st_q, st_d;
  logic [1:0]    pass_q, pass_d;
  logic [CW-1:0] cnt_q, cnt_d, n_q, n_d, i_q, i_d, j_q, j_d;
  logic [IW-1:0] id_q, id_d;
  logic [LW-1:0] lw_q, lw_d, lh_q, lh_d, t_q, t_d, acc_q, acc_d;
  logic [LW-1:0] xs_q, xs_d, tmp_q, tmp_d, fx_q, fx_d, fy_q, fy_d;
  logic [DEPTH_BITS-1:0] mp_vld_q, mp_vld_d;

  logic                out_vld_q, out_vld_d;
  spse_pkg::out_item_t out_q, out_d;

  // Memories.
  logic [IW-1:0] x_mem [spse_pkg::DEPTH];
  logic [IW-1:0] y_mem [spse_pkg::DEPTH];
  logic [SW-1:0] w_mem [spse_pkg::DEPTH];
  logic [SW-1:0] h_mem [spse_pkg::DEPTH];
  logic [IW-1:0] mp_mem [spse_pkg::DEPTH];
  logic [LW-1:0] rl_mem [spse_pkg::DEPTH];
  logic [LW-1:0] loc_mem [4*spse_pkg::DEPTH];

  logic [IW-1:0] x_rd_q, y_rd_q, mp_rd_q;
  logic          mp_vld_rd_q;
  logic [SW-1:0] w_rd_q, h_rd_q;
  logic [LW-1:0] rl_rd_q, loc_rd_q;

  logic          in_acc, ld_we;
  logic [IW-1:0] x_ra, y_ra, wh_ra, rl_ra, rl_wa;
  logic          rl_we, mp_we, loc_we;
  logic [LW-1:0] rl_wd;
  logic [IW+1:0] loc_ra;

  spse_pkg::alu_op_e alu_op;
  logic [LW-1:0]     alu_a, alu_b, alu_res;
  logic              alu_gt;

  logic [CW-1:0] i_rev;
  logic          rev_x, rev_y, i_last, j_last;
  logic [LW-1:0] weight;

  spse_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res),
    .gt_o  (alu_gt)
  );

  assign in_acc = in_valid_i && (st_q == S_LOAD);
  assign ld_we  = in_acc && (cnt_q < MaxCnt);
  assign i_rev  = n_q - CW'(1) - i_q;
  assign rev_x  = pass_q[0] ^ pass_q[1];
  assign rev_y  = pass_q[1];
  assign i_last = (i_q == n_q - CW'(1));
  assign j_last = (j_q == n_q - CW'(1));
  assign weight = pass_q[0] ? LW'(h_rd_q) : LW'(w_rd_q);

  always_ff @(posedge clk_i) begin
    if (ld_we) begin
      x_mem[cnt_q[IW-1:0]] <= in_data_i.x_order_entry;
      y_mem[cnt_q[IW-1:0]] <= in_data_i.y_order_entry;
      w_mem[cnt_q[IW-1:0]] <= in_data_i.module_width & SizeMask;
      h_mem[cnt_q[IW-1:0]] <= in_data_i.module_height & SizeMask;
    end
    x_rd_q <= x_mem[x_ra];
    y_rd_q <= y_mem[y_ra];
    w_rd_q <= w_mem[wh_ra];
    h_rd_q <= h_mem[wh_ra];
  end

  always_ff @(posedge clk_i) begin
    if (mp_we) begin
      mp_mem[y_rd_q] <= i_q[IW-1:0];
    end
    mp_rd_q <= mp_mem[x_rd_q];
  end

  always_ff @(posedge clk_i) begin
    if (rl_we) begin
      rl_mem[rl_wa] <= rl_wd;
    end
    rl_rd_q <= rl_mem[rl_ra];
  end

  always_ff @(posedge clk_i) begin
    if (loc_we) begin
      loc_mem[{pass_q, id_q}] <= rl_rd_q;
    end
    loc_rd_q <= loc_mem[loc_ra];
  end

  always_comb begin
    st_d     = st_q;
    pass_d   = pass_q;
    cnt_d    = cnt_q;
    n_d      = n_q;
    i_d      = i_q;
    j_d      = j_q;
    id_d     = id_q;
    lw_d     = lw_q;
    lh_d     = lh_q;
    t_d      = t_q;
    acc_d    = acc_q;
    xs_d     = xs_q;
    tmp_d    = tmp_q;
    fx_d     = fx_q;
    fy_d     = fy_q;
    mp_vld_d = mp_vld_q;
    out_d    = out_q;
    out_vld_d = out_vld_q && out_stall_i;

    x_ra   = rev_x ? i_rev[IW-1:0] : i_q[IW-1:0];
    y_ra   = rev_y ? i_rev[IW-1:0] : i_q[IW-1:0];
    wh_ra  = (st_q == S_MRD) ? x_rd_q : id_q;
    rl_ra  = j_q[IW-1:0];
    rl_wa  = j_q[IW-1:0];
    rl_wd  = t_q;
    rl_we  = 1'b0;
    mp_we  = 1'b0;
    loc_we = 1'b0;
    loc_ra = {2'd0, i_q[IW-1:0]};
    alu_op = spse_pkg::ALU_SUB;
    alu_a  = acc_q;
    alu_b  = tmp_q;

    case (st_q)
      S_LOAD: begin
        if (ld_we) begin
          cnt_d = cnt_q + CW'(1);
        end
        if (in_acc && in_data_i.last_item) begin
          n_d    = ld_we ? cnt_q + CW'(1) : cnt_q;
          pass_d = 2'd0;
          st_d   = S_INIT;
        end
      end
      S_INIT: begin
        mp_vld_d = '0;
        i_d      = '0;
        st_d     = S_BRD;
      end
      S_BRD: begin
        rl_we = 1'b1;
        rl_wa = i_q[IW-1:0];
        rl_wd = '0;
        st_d  = S_BWR;
      end
      S_BWR: begin
        mp_we            = 1'b1;
        mp_vld_d[y_rd_q] = 1'b1;
        if (i_last) begin
          i_d  = '0;
          st_d = S_XRD;
        end else begin
          i_d  = i_q + CW'(1);
          st_d = S_BRD;
        end
      end
      S_XRD: begin
        st_d = S_MRD;
      end
      S_MRD: begin
        id_d = x_rd_q;
        st_d = S_PSEL;
      end
      S_PSEL: begin
        // An id that never appears in Y falls back to position zero.
        j_d  = mp_vld_rd_q ? CW'(mp_rd_q) : '0;
        st_d = S_LRD;
      end
      S_LRD: begin
        st_d = S_LWR;
      end
      S_LWR: begin
        loc_we = 1'b1;
        alu_op = spse_pkg::ALU_ADD;
        alu_a  = rl_rd_q;
        alu_b  = weight;
        t_d    = alu_res;
        st_d   = S_URD;
      end
      S_URD: begin
        st_d = S_UCMP;
      end
      S_UCMP: begin
        alu_a = t_q;
        alu_b = rl_rd_q;
        if (alu_gt && !j_last) begin
          rl_we = 1'b1;
          j_d   = j_q + CW'(1);
          st_d  = S_URD;
        end else begin
          rl_we = alu_gt;
          if (i_last) begin
            st_d = S_ERD;
          end else begin
            i_d  = i_q + CW'(1);
            st_d = S_XRD;
          end
        end
      end
      S_ERD: begin
        rl_ra = n_q[IW-1:0] - IW'(1);
        st_d  = S_EWR;
      end
      S_EWR: begin
        if (pass_q == 2'd0) begin
          lw_d = rl_rd_q;
        end
        if (pass_q == 2'd1) begin
          lh_d = rl_rd_q;
        end
        if (pass_q == 2'd3) begin
          i_d  = '0;
          st_d = S_O0;
        end else begin
          pass_d = pass_q + 2'd1;
          st_d   = S_INIT;
        end
      end
      S_O0: begin
        wh_ra = i_q[IW-1:0];
        st_d  = S_O1;
      end
      S_O1: begin
        wh_ra  = i_q[IW-1:0];
        fx_d   = loc_rd_q;
        loc_ra = {2'd1, i_q[IW-1:0]};
        st_d   = S_O2;
      end
      S_O2: begin
        wh_ra  = i_q[IW-1:0];
        fy_d   = loc_rd_q;
        loc_ra = {2'd2, i_q[IW-1:0]};
        st_d   = S_O3;
      end
      S_O3: begin
        wh_ra  = i_q[IW-1:0];
        alu_a  = lw_q;
        alu_b  = loc_rd_q;
        acc_d  = alu_res;
        loc_ra = {2'd3, i_q[IW-1:0]};
        st_d   = S_O4;
      end
      S_O4: begin
        wh_ra = i_q[IW-1:0];
        tmp_d = loc_rd_q;
        alu_a = acc_q;
        alu_b = LW'(w_rd_q);
        acc_d = alu_res;
        st_d  = S_O5;
      end
      S_O5: begin
        wh_ra = i_q[IW-1:0];
        alu_a = acc_q;
        alu_b = fx_q;
        xs_d  = alu_res;
        st_d  = S_O6;
      end
      S_O6: begin
        wh_ra = i_q[IW-1:0];
        alu_a = lh_q;
        alu_b = tmp_q;
        acc_d = alu_res;
        st_d  = S_O7;
      end
      S_O7: begin
        wh_ra = i_q[IW-1:0];
        alu_a = acc_q;
        alu_b = LW'(h_rd_q);
        acc_d = alu_res;
        st_d  = S_O8;
      end
      S_O8: begin
        wh_ra = i_q[IW-1:0];
        alu_a = acc_q;
        alu_b = fy_q;
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d           = 1'b1;
          out_d.module_index  = i_q[IW-1:0];
          out_d.x_position    = fx_q;
          out_d.y_position    = fy_q;
          out_d.x_slack       = xs_q;
          out_d.y_slack       = alu_res;
          out_d.layout_width  = lw_q;
          out_d.layout_height = lh_q;
          out_d.last_result   = i_last;
          if (i_last) begin
            cnt_d = '0;
            st_d  = S_LOAD;
          end else begin
            i_d  = i_q + CW'(1);
            st_d = S_O0;
          end
        end
      end
      default: begin
        st_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_LOAD;
      pass_q    <= '0;
      cnt_q     <= '0;
      n_q       <= '0;
      i_q       <= '0;
      j_q       <= '0;
      mp_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      pass_q    <= pass_d;
      cnt_q     <= cnt_d;
      n_q       <= n_d;
      i_q       <= i_d;
      j_q       <= j_d;
      mp_vld_q  <= mp_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q        <= id_d;
    lw_q        <= lw_d;
    lh_q        <= lh_d;
    t_q         <= t_d;
    acc_q       <= acc_d;
    xs_q        <= xs_d;
    tmp_q       <= tmp_d;
    fx_q        <= fx_d;
    fy_q        <= fy_d;
    out_q       <= out_d;
    mp_vld_rd_q <= mp_vld_q[x_rd_q];
  end

  assign in_stall_o  = (st_q != S_LOAD);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
